/* rtl/wld_pkg.sv */
// Package: shared types, codes and reset constants of the work lease dispatcher.
`timescale 1ns / 1ps

package wld_pkg;

    // Defaults for the top-level parameters.
    localparam int LEASE_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF   = 32;

    // Field widths fixed by the interface.
    localparam int UNIT_W    = 16;
    localparam int SCORE_W   = 20;
    localparam int SETTING_W = 29;
    localparam int TMO_W     = 31;
    localparam int OPEN_W    = 7;
    localparam int CFG_IDX_W = 2;

    // Register reset values.
    localparam logic [TMO_W-1:0]  LEASE_TIMEOUT_RST = TMO_W'(60 * 60);
    localparam logic [UNIT_W-1:0] UNIT_TOTAL_RST    = UNIT_W'(672);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEASE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TOTAL    = 2'd1;

    // Action codes of an input beat.
    localparam logic [1:0] ACT_REQUEST = 2'd0;
    localparam logic [1:0] ACT_REPORT  = 2'd1;
    localparam logic [1:0] ACT_TICK    = 2'd2;

    // Reply kinds of a result beat.
    localparam logic [1:0] KIND_ASSIGNED = 2'd0;
    localparam logic [1:0] KIND_ALL_DONE = 2'd1;
    localparam logic [1:0] KIND_TICK_ACK = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RETIRE,
        S_SEARCH
    } t_state;

    // Commands broadcast from the controller to every lease cell.
    typedef struct packed {
        logic              retire;
        logic              refresh;
        logic              append;
        logic [UNIT_W-1:0] done_unit;
        logic [UNIT_W-1:0] fresh_unit;
    } t_cell_ctrl;

endpackage

/* rtl/wld_cell.sv */
// Lease cell: one slot of the packed lease table with its neighbor links.
`timescale 1ns / 1ps

module wld_cell import wld_pkg::*; #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int CNT_W     = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctrl           i_ctrl,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [TMO_W-1:0]     i_timeout,
    input  logic [CNT_W-1:0]     i_count,
    input  logic                 i_match_seen,
    output logic                 o_match_seen,
    input  logic                 i_hit_seen,
    output logic                 o_hit_seen,
    input  logic [UNIT_W-1:0]    i_hit_unit,
    output logic [UNIT_W-1:0]    o_hit_unit,
    input  logic                 i_nb_valid,
    input  logic [UNIT_W-1:0]    i_nb_unit,
    input  logic [TIME_BITS-1:0] i_nb_start,
    output logic                 o_valid,
    output logic [UNIT_W-1:0]    o_unit,
    output logic [TIME_BITS-1:0] o_start
);

    localparam int CMP_W = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

    logic                 r_valid;
    logic [UNIT_W-1:0]    r_unit;
    logic [TIME_BITS-1:0] r_start;
    logic                 my_match;
    logic                 take_shift;
    logic [TIME_BITS-1:0] age;
    logic                 expired;
    logic                 first_hit;
    logic                 do_append;

    always_comb begin
        my_match     = r_valid && (r_unit == i_ctrl.done_unit);
        o_match_seen = i_match_seen || my_match;
        // Every slot from the first match onward pulls its right neighbor in.
        take_shift   = i_ctrl.retire && o_match_seen;
        age          = i_now - r_start;
        expired      = r_valid && (CMP_W'(age) > CMP_W'(i_timeout));
        first_hit    = expired && !i_hit_seen;
        o_hit_seen   = i_hit_seen || expired;
        o_hit_unit   = i_hit_unit | (first_hit ? r_unit : '0);
        do_append    = i_ctrl.append && (i_count == CNT_W'(IDX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take_shift) begin
            r_valid <= i_nb_valid;
        end else if (do_append) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_shift) begin
            r_unit  <= i_nb_unit;
            r_start <= i_nb_start;
        end else if (do_append) begin
            r_unit  <= i_ctrl.fresh_unit;
            r_start <= i_now;
        end else if (i_ctrl.refresh && first_hit) begin
            r_start <= i_now;
        end
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_start = r_start;

endmodule

/* rtl/work_lease_dispatcher_unit.sv */
// Top level: controller, state registers and the chain of lease cells.
`timescale 1ns / 1ps

// The work lease dispatcher hands out numbered work units under time leases.
// Input beats carry an action: a request, a completion report (which first
// retires the reported unit and may raise the best score), or a time tick.
// Each input beat produces exactly one result beat carrying the reply kind,
// the assigned unit and the progress and best-score status.
// The lease table is a row of cells in insertion order. A retire shifts the
// cells behind the match one place toward the head in the retire step; the
// first expired lease in the row is found by a hit flag rippling down the row.
// An item passes through three steps from acceptance to its result: the idle
// state takes the beat, the retire state does the retire shift and best-score
// update, and the search state does the expiry search, issue and table update.
// One item is in work at a time; no new beat is taken until its result commits.
// The result sits in an output register; while the receiver stalls, the next
// item is accepted and worked up to its search step, which then waits for
// the output register to free up. A stalled result beat does not change.
// Configuration writes are always ready and take effect at once; they are
// to be issued only while no item is in work.
// Synchronous reset empties the lease table, zeroes time, progress and best
// score, and restores the register defaults. No clearing pass is needed.
module work_lease_dispatcher_unit import wld_pkg::*; #(
    parameter int LEASE_DEPTH = LEASE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TMO_W-1:0]     i_cfg_data,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic [UNIT_W-1:0]    i_done_unit,
    input  logic [SCORE_W-1:0]   i_done_score,
    input  logic [SETTING_W-1:0] i_done_setting,
    // Output channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_reply_kind,
    output logic [UNIT_W-1:0]    o_assigned_unit,
    output logic                 o_untracked,
    output logic [UNIT_W-1:0]    o_issued_count,
    output logic [OPEN_W-1:0]    o_open_leases,
    output logic [SCORE_W-1:0]   o_best_score,
    output logic [SETTING_W-1:0] o_best_setting
);

    localparam int CNT_W = $clog2(LEASE_DEPTH + 1);

    // Control state.
    t_state               r_state;
    t_state               n_state;
    logic [TMO_W-1:0]     r_timeout;
    logic [UNIT_W-1:0]    r_unit_total;
    logic [TIME_BITS-1:0] r_now;
    logic [UNIT_W-1:0]    r_next_fresh;
    logic [CNT_W-1:0]     r_count;
    logic [SCORE_W-1:0]   r_top_score;
    logic [SETTING_W-1:0] r_top_setting;
    logic                 r_out_valid;

    // Captured input beat.
    logic [1:0]           r_action;
    logic [UNIT_W-1:0]    r_done_unit;
    logic [SCORE_W-1:0]   r_done_score;
    logic [SETTING_W-1:0] r_done_setting;

    // Result register.
    logic [1:0]           r_kind;
    logic [UNIT_W-1:0]    r_assigned;
    logic                 r_untracked;
    logic [UNIT_W-1:0]    r_issued;
    logic [OPEN_W-1:0]    r_open;
    logic [SCORE_W-1:0]   r_best_score;
    logic [SETTING_W-1:0] r_best_setting;

    // Controller decisions.
    logic                 accept;
    logic                 commit;
    logic                 retire_step;
    logic                 is_unit_req;
    logic                 retired;
    logic                 hit_any;
    logic [UNIT_W-1:0]    hit_unit;
    logic                 do_refresh;
    logic                 do_fresh;
    logic                 table_full;
    logic [1:0]           n_kind;
    logic [UNIT_W-1:0]    n_assigned;
    logic                 n_untracked;
    logic [UNIT_W-1:0]    n_issued;
    logic [CNT_W-1:0]     n_count;
    logic [OPEN_W-1:0]    n_open;
    logic [CNT_W+OPEN_W-1:0] count_x;
    t_cell_ctrl           cell_ctrl;

    // Neighbor links of the cell row; the extra slot closes the row.
    logic                 match_chain [LEASE_DEPTH+1];
    logic                 hit_chain   [LEASE_DEPTH+1];
    logic [UNIT_W-1:0]    unit_chain  [LEASE_DEPTH+1];
    logic                 cell_valid  [LEASE_DEPTH+1];
    logic [UNIT_W-1:0]    cell_unit   [LEASE_DEPTH+1];
    logic [TIME_BITS-1:0] cell_start  [LEASE_DEPTH+1];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_RETIRE;
            S_RETIRE: n_state = S_SEARCH;
            S_SEARCH: if (commit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State-machine outputs.
    always_comb begin
        o_in_stall  = 1'b1;
        retire_step = 1'b0;
        commit      = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_stall  = 1'b0;
            S_RETIRE: retire_step = 1'b1;
            S_SEARCH: commit      = !r_out_valid || !i_out_stall;
            default:  o_in_stall  = 1'b1;
        endcase
    end

    assign accept      = i_in_valid && !o_in_stall;
    assign is_unit_req = (r_action == ACT_REQUEST) || (r_action == ACT_REPORT);
    assign retired     = match_chain[LEASE_DEPTH];
    assign hit_any     = hit_chain[LEASE_DEPTH];
    assign hit_unit    = unit_chain[LEASE_DEPTH];
    assign table_full  = (r_count == CNT_W'(LEASE_DEPTH));

    // Issue: reissue the first expired lease in the row, else a fresh unit.
    always_comb begin
        n_kind      = KIND_TICK_ACK;
        n_assigned  = '0;
        n_untracked = 1'b0;
        do_refresh  = 1'b0;
        do_fresh    = 1'b0;
        if (is_unit_req) begin
            n_kind = KIND_ALL_DONE;
            if (hit_any) begin
                if (hit_unit < r_unit_total) begin
                    n_kind     = KIND_ASSIGNED;
                    n_assigned = hit_unit;
                    do_refresh = 1'b1;
                end
            end else if (r_next_fresh < r_unit_total) begin
                n_kind      = KIND_ASSIGNED;
                n_assigned  = r_next_fresh;
                n_untracked = table_full;
                do_fresh    = 1'b1;
            end
        end
    end

    always_comb begin
        cell_ctrl.retire     = retire_step && (r_action == ACT_REPORT);
        cell_ctrl.refresh    = commit && do_refresh;
        cell_ctrl.append     = commit && do_fresh && !table_full;
        cell_ctrl.done_unit  = r_done_unit;
        cell_ctrl.fresh_unit = r_next_fresh;
    end

    assign match_chain[0]           = 1'b0;
    assign hit_chain[0]             = 1'b0;
    assign unit_chain[0]            = '0;
    assign cell_valid[LEASE_DEPTH]  = 1'b0;
    assign cell_unit[LEASE_DEPTH]   = '0;
    assign cell_start[LEASE_DEPTH]  = '0;

    for (genvar g = 0; g < LEASE_DEPTH; g++) begin : g_cell
        wld_cell #(
            .IDX       (g),
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_now        (r_now),
            .i_timeout    (r_timeout),
            .i_count      (r_count),
            .i_match_seen (match_chain[g]),
            .o_match_seen (match_chain[g+1]),
            .i_hit_seen   (hit_chain[g]),
            .o_hit_seen   (hit_chain[g+1]),
            .i_hit_unit   (unit_chain[g]),
            .o_hit_unit   (unit_chain[g+1]),
            .i_nb_valid   (cell_valid[g+1]),
            .i_nb_unit    (cell_unit[g+1]),
            .i_nb_start   (cell_start[g+1]),
            .o_valid      (cell_valid[g]),
            .o_unit       (cell_unit[g]),
            .o_start      (cell_start[g])
        );
    end

    // Control and status registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_timeout     <= LEASE_TIMEOUT_RST;
            r_unit_total  <= UNIT_TOTAL_RST;
            r_now         <= '0;
            r_next_fresh  <= '0;
            r_count       <= '0;
            r_top_score   <= '0;
            r_top_setting <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_LEASE_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end else if (i_cfg_index == REG_UNIT_TOTAL) begin
                    r_unit_total <= i_cfg_data[UNIT_W-1:0];
                end
            end
            if (cell_ctrl.retire) begin
                if (retired) begin
                    r_count <= r_count - CNT_W'(1);
                end
                if (r_done_score > r_top_score) begin
                    r_top_score   <= r_done_score;
                    r_top_setting <= r_done_setting;
                end
            end
            if (commit) begin
                if (r_action == ACT_TICK) begin
                    r_now <= r_now + TIME_BITS'(1);
                end
                if (do_fresh) begin
                    r_next_fresh <= r_next_fresh + UNIT_W'(1);
                end
                if (cell_ctrl.append) begin
                    r_count <= r_count + CNT_W'(1);
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status as it stands once the committing item has updated the table.
    // The next item's retire step may move the live registers while this
    // result still waits, so the status is captured with the result.
    always_comb begin
        n_issued = do_fresh ? (r_next_fresh + UNIT_W'(1)) : r_next_fresh;
        n_count  = cell_ctrl.append ? (r_count + CNT_W'(1)) : r_count;
        count_x  = (CNT_W + OPEN_W)'(n_count);
        n_open   = (count_x > (CNT_W + OPEN_W)'(127)) ?
                   OPEN_W'(127) : count_x[OPEN_W-1:0];
    end

    // Input capture and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action       <= i_action;
            r_done_unit    <= i_done_unit;
            r_done_score   <= i_done_score;
            r_done_setting <= i_done_setting;
        end
        if (commit) begin
            r_kind         <= n_kind;
            r_assigned     <= n_assigned;
            r_untracked    <= n_untracked;
            r_issued       <= n_issued;
            r_open         <= n_open;
            r_best_score   <= r_top_score;
            r_best_setting <= r_top_setting;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_reply_kind    = r_kind;
    assign o_assigned_unit = r_assigned;
    assign o_untracked     = r_untracked;
    assign o_issued_count  = r_issued;
    assign o_open_leases   = r_open;
    assign o_best_score    = r_best_score;
    assign o_best_setting  = r_best_setting;

endmodule
